>>> hdl/qkt_pkg.sv
// ----------------------------------------------------------------------------
// Quarantine key table package
// Shared widths, command and status codes, and the structs that run along
// the cell chain.
// ----------------------------------------------------------------------------
package qkt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int KEY_W       = 64;
    localparam int STAMP_W     = 64;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 2;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_ENABLED = 2'd0;

    // operation carried by a request once it has been checked
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_REMOVE,
        OP_QUERY
    } op_t;

    // request payload seen by every cell
    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } bcast_t;

    // token handed from cell to cell
    typedef struct packed {
        logic active;
        logic found;
    } token_t;

endpackage

>>> hdl/quarantine_key_table.sv
// ----------------------------------------------------------------------------
// Quarantine key table
// Densely packed table of device keys with removal timestamps: add or
// refresh, remove with compaction, and presence query.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------
//  in        sink       in_valid / in_stall  cmd, device_key, removal_time
//  out       source     out_valid/out_stall  status, present, entry_count
//  config    APB slave  psel/penable/pready  paddr, pwdata, prdata
//
//  A request walks the row of MAX_ENTRIES cells one cell per cycle; a new
//  request is accepted only after the previous one has left the row and
//  its result has been handed to the output register.
//  Reset clears the entry count, the enable register, the chain tokens and
//  the control state; table contents are not cleared.
//  A result held by out_stall does not stop the next request from being
//  accepted; a finished request waits in the hold state until the output
//  register is free.
//
module quarantine_key_table #(
    parameter int MAX_ENTRIES = qkt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [qkt_pkg::CMD_W-1:0]         cmd,
    input  logic [qkt_pkg::KEY_W-1:0]         device_key,
    input  logic [qkt_pkg::STAMP_W-1:0]       removal_time,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [qkt_pkg::STATUS_W-1:0]      status,
    output logic                              present,
    output logic [qkt_pkg::COUNT_OUT_W-1:0]   entry_count,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qkt_pkg::ADDR_W-1:0]        paddr,
    input  logic [qkt_pkg::DATA_W-1:0]        pwdata,
    output logic [qkt_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import qkt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    // control state
    state_t               state_reg;
    state_t               state_next;
    logic                 launch_reg;
    logic                 launch_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 enabled_reg;
    logic                 enabled_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // request and result payload
    bcast_t               bcast_reg;
    bcast_t               bcast_next;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [STATUS_W-1:0]  res_status_next;
    logic                 res_present_reg;
    logic                 res_present_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 present_reg;
    logic                 present_next;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_next;

    // cell row
    token_t               tok_chain [MAX_ENTRIES+1];
    logic [KEY_W-1:0]     cell_key  [MAX_ENTRIES];
    logic [STAMP_W-1:0]   cell_stamp[MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES:0]   active_vec;

    logic                 in_accept;
    logic                 cfg_write;
    logic                 chain_end;
    logic                 chain_found;
    logic                 out_free;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    // ------------------------------------------------------------------
    // Cell row: the token enters cell 0 the cycle after acceptance
    // ------------------------------------------------------------------
    assign tok_chain[0].active = launch_reg;
    assign tok_chain[0].found  = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [KEY_W-1:0]   nb_key;
        logic [STAMP_W-1:0] nb_stamp;

        if (g < MAX_ENTRIES - 1)
        begin : g_mid
            assign nb_key   = cell_key[g+1];
            assign nb_stamp = cell_stamp[g+1];
        end
        else
        begin : g_last
            // no right neighbor: hold own contents
            assign nb_key   = cell_key[g];
            assign nb_stamp = cell_stamp[g];
        end

        qkt_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bcast    (bcast_reg),
            .count    (count_reg),
            .tok_in   (tok_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .nb_key   (nb_key),
            .nb_stamp (nb_stamp),
            .key      (cell_key[g]),
            .stamp    (cell_stamp[g]),
            .match    (match_vec[g])
        );
    end

    for (genvar t = 0; t <= MAX_ENTRIES; t++)
    begin : g_active
        assign active_vec[t] = tok_chain[t].active;
    end

    assign chain_end   = tok_chain[MAX_ENTRIES].active;
    assign chain_found = tok_chain[MAX_ENTRIES].found;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_ENABLED)
        begin
            prdata[0] = enabled_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        launch_next      = 1'b0;
        count_next       = count_reg;
        enabled_next     = enabled_reg;
        out_valid_next   = out_valid_reg;
        bcast_next       = bcast_reg;
        res_status_next  = res_status_reg;
        res_present_next = res_present_reg;
        status_next      = status_reg;
        present_next     = present_reg;
        count_out_next   = count_out_reg;

        // every address writes the single register; only pwdata[0] is kept as enable
        if (cfg_write)
        begin
            enabled_next = pwdata[0];
        end

        // drop the delivered result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    bcast_next.key   = device_key;
                    bcast_next.stamp = removal_time;
                    if (!enabled_reg || device_key == '0)
                    begin
                        bcast_next.op = OP_NONE;
                    end
                    else
                    begin
                        unique case (cmd)
                            CMD_ADD:    bcast_next.op = OP_ADD;
                            CMD_REMOVE: bcast_next.op = OP_REMOVE;
                            CMD_QUERY:  bcast_next.op = OP_QUERY;
                            default:    bcast_next.op = OP_NONE;
                        endcase
                    end
                    launch_next = 1'b1;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                // settle status and count once the token leaves the row
                if (chain_end)
                begin
                    res_present_next = 1'b0;
                    unique case (bcast_reg.op)
                        OP_ADD:
                        begin
                            if (chain_found)
                            begin
                                res_status_next = ST_OK;
                            end
                            else if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_status_next = ST_OK;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (chain_found)
                            begin
                                res_status_next = ST_OK;
                                count_next      = count_reg - 1'b1;
                            end
                            else
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_status_next  = ST_OK;
                            res_present_next = chain_found;
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    status_next    = res_status_reg;
                    present_next   = res_present_reg;
                    count_out_next = enabled_reg ? count_ext[COUNT_OUT_W-1:0] : '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            count_reg     <= '0;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            enabled_reg   <= enabled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcast_reg       <= bcast_next;
        res_status_reg  <= res_status_next;
        res_present_reg <= res_present_next;
        status_reg      <= status_next;
        present_reg     <= present_next;
        count_out_reg   <= count_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign present     = present_reg;
    assign entry_count = count_out_reg;

`ifndef NO_ASSERTIONS
    // keys are unique, so a request hits at most one cell
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matched the request key");

    // only one request travels the row at a time
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one token in the cell row");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // the count moves only when a request leaves the row
    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_RUN && chain_end))
        else $error("entry count changed outside request completion");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("result presented without a finished request");
`endif

endmodule

>>> hdl/qkt_cell.sv
// ----------------------------------------------------------------------------
// Quarantine key table cell
// One table slot: key and timestamp, plus the token stage that carries a
// request past the slot and on to the next cell.
// ----------------------------------------------------------------------------
module qkt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qkt_pkg::bcast_t               bcast,
    input  logic [CNT_W-1:0]              count,
    input  qkt_pkg::token_t               tok_in,
    output qkt_pkg::token_t               tok_out,
    input  logic [qkt_pkg::KEY_W-1:0]     nb_key,
    input  logic [qkt_pkg::STAMP_W-1:0]   nb_stamp,
    output logic [qkt_pkg::KEY_W-1:0]     key,
    output logic [qkt_pkg::STAMP_W-1:0]   stamp,
    output logic                          match
);
    import qkt_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;
    token_t             tok_reg;
    token_t             tok_next;
    logic               slot_used;
    logic               slot_free;

    always_comb
    begin
        slot_used  = count > CNT_W'(INDEX);
        slot_free  = count == CNT_W'(INDEX);
        match      = tok_in.active && slot_used && (bcast.op != OP_NONE)
                     && (key_reg == bcast.key);
        key_next   = key_reg;
        stamp_next = stamp_reg;
        if (tok_in.active)
        begin
            unique case (bcast.op)
                OP_ADD:
                begin
                    // refresh in place, or append at the first free slot
                    if (match)
                    begin
                        stamp_next = bcast.stamp;
                    end
                    else if (!tok_in.found && slot_free)
                    begin
                        key_next   = bcast.key;
                        stamp_next = bcast.stamp;
                    end
                end
                OP_REMOVE:
                begin
                    // pull the right neighbor down from the hit onward
                    if (slot_used && (match || tok_in.found))
                    begin
                        key_next   = nb_key;
                        stamp_next = nb_stamp;
                    end
                end
                default:
                begin
                end
            endcase
        end
        tok_next.active = tok_in.active;
        tok_next.found  = tok_in.found | match;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        stamp_reg <= stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign key     = key_reg;
    assign stamp   = stamp_reg;
    assign tok_out = tok_reg;

endmodule
